// File: hw/rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the softmax temperature policy unit.
// ----------------------------------------------------------------------------
package stp_pkg;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUM,
    ST_PREP,
    ST_BEST,
    ST_SCAN,
    ST_HOT,
    ST_WRD,
    ST_WNUM,
    ST_WSUB,
    ST_WCHK,
    ST_WDIV,
    ST_WEXP,
    ST_WWR,
    ST_NRD,
    ST_NDAT,
    ST_NDIV,
    ST_NWR,
    ST_RESP,
    ST_RDWAIT
  } stp_state_t;

  // Transaction modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Configuration register indexes
  localparam logic CFG_TEMPERATURE = 1'b0;
  localparam logic CFG_CENTRE      = 1'b1;

  // Register reset values
  localparam logic [15:0] TEMP_RESET   = 16'd256;
  localparam logic        CENTRE_RESET = 1'b1;

  // Arithmetic constants
  localparam int EXP_LIMIT   = 50;
  localparam int LOG2E_Q16   = 94548;
  localparam int POLY_A      = 43024;
  localparam int POLY_B      = 10256;
  localparam int ONE_Q16     = 65536;
  localparam int EXP_K_LIMIT = 17;
  localparam int PROB_MAX    = 65535;

  // Quotient bits of the shared divider, exp argument and weight widths
  localparam int DIV_QW = 21;
  localparam int WGT_W  = 17;

endpackage

// File: hw/rtl/stp_ram.sv
// ----------------------------------------------------------------------------
// stp_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module stp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/stp_div.sv
// ----------------------------------------------------------------------------
// stp_div
// Restoring divider, one quotient bit per cycle, fixed quotient width.
// The caller guarantees dividend < divisor * 2**DIV_QW.
// ----------------------------------------------------------------------------
module stp_div #(
  parameter int DW = 27
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [DW+stp_pkg::DIV_QW-1:0]    dividend,
  input  logic [DW-1:0]                    divisor,
  output logic                             done,
  output logic [stp_pkg::DIV_QW-1:0]       quotient
);
  import stp_pkg::*;

  localparam int CNT_W = $clog2(DIV_QW + 1);

  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     div_r;
  logic [DIV_QW-1:0] low_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DW:0]       trial;
  logic              take;

  // Bring down the next dividend bit and try the subtract
  assign trial = {rem_r, low_r[DIV_QW-1]};
  assign take  = (trial >= {1'b0, div_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIV_QW);
    end else if (busy_r) begin
      busy_r <= (cnt_r != CNT_W'(1));
      done_r <= (cnt_r == CNT_W'(1));
      cnt_r  <= cnt_r - 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: quotient bits shift into the low word
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DW+DIV_QW-1:DIV_QW];
      low_r <= dividend[DIV_QW-1:0];
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? DW'(trial - {1'b0, div_r}) : trial[DW-1:0];
      low_r <= {low_r[DIV_QW-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = low_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
`endif

endmodule

// File: hw/rtl/stp_exp.sv
// ----------------------------------------------------------------------------
// stp_exp
// Four-stage pipelined fixed-point 2**(-m*log2e) weight, Q16 result.
// ----------------------------------------------------------------------------
module stp_exp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [stp_pkg::DIV_QW-1:0]      m,
  output logic                            out_vld,
  output logic [stp_pkg::WGT_W-1:0]       weight
);
  import stp_pkg::*;

  logic [37:0]      prod1;
  logic [31:0]      prod2;
  logic [31:0]      prod3;
  logic [5:0]       k1_r, k2_r, k3_r;
  logic [15:0]      f1_r, f2_r;
  logic [15:0]      a2_r;
  logic [WGT_W-1:0] p3_r;
  logic [WGT_W-1:0] w_r;
  logic [3:0]       vld_r;

  assign prod1 = 38'(m) * 38'(LOG2E_Q16);
  assign prod2 = 32'(f1_r) * 32'(POLY_B);
  assign prod3 = 32'(f2_r) * 32'(a2_r);

  // Valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // Stages: scale by log2e, polynomial inner term, outer term, shift by k
  always_ff @(posedge clk) begin
    k1_r <= prod1[37:32];
    f1_r <= prod1[31:16];
    k2_r <= k1_r;
    f2_r <= f1_r;
    a2_r <= 16'(32'(POLY_A) - {16'd0, prod2[31:16]});
    k3_r <= k2_r;
    p3_r <= WGT_W'(32'(ONE_Q16) - {16'd0, prod3[31:16]});
    w_r  <= (k3_r >= 6'(EXP_K_LIMIT)) ? '0 : (p3_r >> k3_r);
  end

  assign out_vld = vld_r[3];
  assign weight  = w_r;

endmodule

// File: hw/rtl/softmax_temperature_policy_unit.sv
// ----------------------------------------------------------------------------
// softmax_temperature_policy_unit
// Temperature softmax over a stored score set, probabilities kept in RAM.
// ----------------------------------------------------------------------------
// Loads without last leave busy low. A read returns its result from the read-wait state.
// Last load: mean pass (centring on), max scan, then either a one-hot fill or the
//   weight and normalize passes over the entries, which use the shared 21-step divider;
//   the result strobes after the response state.
// The receiver cannot stall: each result stands for exactly one cycle.
// Reset clears state, counters, flags and the result strobe and loads config defaults;
// datapath and result data registers and RAM contents stay undefined.
module softmax_temperature_policy_unit #(
  parameter int MAX_ENTRIES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_score,
  input  logic        in_last,
  input  logic        in_negate,
  input  logic [8:0]  in_read_index,
  output logic        out_valid,
  output logic [15:0] out_probability,
  output logic        out_deterministic,
  output logic [9:0]  out_entry_count,
  output logic        out_index_miss,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import stp_pkg::*;

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = CW + 17;
  localparam int DEN_W = CW + 16;
  localparam int CMP_W = CW + 24;
  localparam int Z_W   = CW + 17;
  localparam int DW    = CW + 17;
  localparam int NW    = DW + DIV_QW;

  stp_state_t state_r, state_nxt;

  logic [15:0]            temp_r;
  logic                   centre_r;
  logic [CW-1:0]          cnt_r;
  logic                   flag_r;
  logic                   closed_r;
  logic                   neg_r;
  logic                   hit_r;
  logic                   hot_r;
  logic [CW-1:0]          idx_r;
  logic [CW-1:0]          di_r, ni_r, imax_r;
  logic                   rv_r, nv_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [DEN_W-1:0]       den_r;
  logic signed [CMP_W-1:0] best_r, nmax_r, num_r;
  logic [CMP_W-1:0]       e_r;
  logic [WGT_W-1:0]       wgt_r;
  logic [Z_W-1:0]         z_r;
  logic [15:0]            pq_r;

  logic                   out_valid_r;
  logic [15:0]            out_prob_r;
  logic                   out_det_r;
  logic [CW-1:0]          out_cnt_r;
  logic                   out_miss_r;

  // Handshake and load decode
  logic              accept;
  logic [CW-1:0]     cnt_eff;
  logic              room;
  logic [CW-1:0]     cnt_new;
  logic [31:0]       rd_idx32;
  logic              rd_hit;
  logic [15:0]       tmp_eff;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign cnt_eff  = closed_r ? '0 : cnt_r;
  assign room     = ({{(32-CW){1'b0}}, cnt_eff} < 32'(MAX_ENTRIES));
  assign cnt_new  = cnt_eff + CW'(room);
  assign rd_idx32 = {23'd0, in_read_index};
  assign rd_hit   = closed_r && (rd_idx32 < {{(32-CW){1'b0}}, cnt_r});
  assign tmp_eff  = (temp_r == 16'd0) ? 16'd1 : temp_r;

  // Memories
  logic            sc_we;
  logic [AW-1:0]   sc_addr;
  logic [15:0]     sc_rdata;
  logic            pr_we;
  logic [AW-1:0]   pr_addr;
  logic [WGT_W-1:0] pr_wdata;
  logic [WGT_W-1:0] pr_rdata;

  stp_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_score_ram (
    .clk   (clk),
    .we    (sc_we),
    .addr  (sc_addr),
    .wdata (in_score),
    .rdata (sc_rdata)
  );

  stp_ram #(.WIDTH(WGT_W), .DEPTH(MAX_ENTRIES)) u_prob_ram (
    .clk   (clk),
    .we    (pr_we),
    .addr  (pr_addr),
    .wdata (pr_wdata),
    .rdata (pr_rdata)
  );

  // Score as read back: optional negation, centred numerator
  logic signed [16:0]   s17, v_s;
  logic signed [CW+17:0] prod_vn;
  logic signed [CMP_W-1:0] num_full;

  assign s17      = signed'({sc_rdata[15], sc_rdata});
  assign v_s      = neg_r ? -s17 : s17;
  assign prod_vn  = v_s * $signed({1'b0, cnt_r});
  assign num_full = CMP_W'(prod_vn) - CMP_W'(sum_r);

  // Shared divider and exp pipeline
  logic              div_start;
  logic [NW-1:0]     div_dividend;
  logic [DW-1:0]     div_divisor;
  logic              div_done;
  logic [DIV_QW-1:0] div_q;
  logic              exp_start;
  logic              exp_vld;
  logic [WGT_W-1:0]  exp_w;
  logic              sat_zero;

  assign sat_zero = (e_r >= (CMP_W'(den_r) << 5));

  stp_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  stp_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (exp_start),
    .m       (div_q),
    .out_vld (exp_vld),
    .weight  (exp_w)
  );

  // Pass completion
  logic idx_end, sum_done, scan_done, last_entry;
  assign idx_end    = (idx_r == cnt_r);
  assign sum_done   = idx_end && !rv_r;
  assign scan_done  = idx_end && !rv_r && !nv_r;
  assign last_entry = (idx_r == cnt_r - 1'b1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_READ) begin
            state_nxt = ST_RDWAIT;
          end else if (in_last) begin
            state_nxt = centre_r ? ST_SUM : ST_PREP;
          end
        end
      end
      ST_SUM:    if (sum_done) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = ST_BEST;
      ST_BEST:   state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_done) state_nxt = hot_r ? ST_HOT : ST_WRD;
      ST_HOT:    if (last_entry) state_nxt = ST_RESP;
      ST_WRD:    state_nxt = ST_WNUM;
      ST_WNUM:   state_nxt = ST_WSUB;
      ST_WSUB:   state_nxt = ST_WCHK;
      ST_WCHK:   state_nxt = sat_zero ? ST_WWR : ST_WDIV;
      ST_WDIV:   if (div_done) state_nxt = ST_WEXP;
      ST_WEXP:   if (exp_vld) state_nxt = ST_WWR;
      ST_WWR:    state_nxt = last_entry ? ST_NRD : ST_WRD;
      ST_NRD:    state_nxt = ST_NDAT;
      ST_NDAT:   state_nxt = ST_NDIV;
      ST_NDIV:   if (div_done) state_nxt = ST_NWR;
      ST_NWR:    state_nxt = last_entry ? ST_RESP : ST_NRD;
      ST_RESP:   state_nxt = ST_IDLE;
      ST_RDWAIT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory and unit controls
  always_comb begin
    sc_we        = 1'b0;
    sc_addr      = idx_r[AW-1:0];
    pr_we        = 1'b0;
    pr_addr      = idx_r[AW-1:0];
    pr_wdata     = wgt_r;
    div_start    = 1'b0;
    div_dividend = {{(NW-DEN_W-21){1'b0}}, e_r[DEN_W+4:0], 16'd0};
    div_divisor  = DW'(den_r);
    exp_start    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        sc_addr = cnt_eff[AW-1:0];
        sc_we   = accept && (in_mode == MODE_LOAD) && room;
        pr_addr = rd_idx32[AW-1:0];
      end
      ST_HOT: begin
        pr_we    = 1'b1;
        pr_wdata = (idx_r == imax_r) ? WGT_W'(PROB_MAX) : '0;
      end
      ST_WCHK: begin
        div_start = !sat_zero;
      end
      ST_WDIV: begin
        exp_start = div_done;
      end
      ST_WWR: begin
        pr_we = 1'b1;
      end
      ST_NDAT: begin
        div_start    = 1'b1;
        div_dividend = {{(NW-33){1'b0}}, pr_rdata, 16'd0} +
                       {{(NW-Z_W+1){1'b0}}, z_r[Z_W-1:1]};
        div_divisor  = z_r;
      end
      ST_NWR: begin
        pr_we    = 1'b1;
        pr_wdata = {1'b0, pq_r};
      end
      default: begin
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      temp_r      <= TEMP_RESET;
      centre_r    <= CENTRE_RESET;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      nv_r        <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_RESP) || (state_r == ST_RDWAIT);

      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TEMPERATURE: temp_r   <= cfg_data;
          CFG_CENTRE:      centre_r <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state_r) inside
        ST_IDLE: begin
          if (accept && (in_mode == MODE_LOAD)) begin
            cnt_r    <= cnt_new;
            flag_r   <= 1'b0;
            closed_r <= in_last;
            idx_r    <= '0;
            rv_r     <= 1'b0;
            nv_r     <= 1'b0;
          end
        end
        ST_SUM, ST_SCAN: begin
          if ((state_r == ST_SUM && sum_done) || (state_r == ST_SCAN && scan_done)) begin
            idx_r <= '0;
            rv_r  <= 1'b0;
            nv_r  <= 1'b0;
          end else begin
            rv_r <= !idx_end;
            nv_r <= (state_r == ST_SCAN) && rv_r;
            if (!idx_end) begin
              idx_r <= idx_r + 1'b1;
            end
          end
          if (state_r == ST_SCAN && scan_done && hot_r) begin
            flag_r <= 1'b1;
          end
        end
        ST_HOT, ST_WWR, ST_NWR: begin
          idx_r <= last_entry ? '0 : idx_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_r <= in_negate;
          hit_r <= rd_hit;
          sum_r <= '0;
          hot_r <= 1'b0;
        end
      end
      ST_SUM: begin
        if (rv_r) begin
          sum_r <= sum_r + SUM_W'(v_s);
        end
      end
      ST_PREP: begin
        den_r <= DEN_W'(cnt_r) * DEN_W'(tmp_eff);
      end
      ST_BEST: begin
        best_r <= $signed(CMP_W'(den_r) * CMP_W'(EXP_LIMIT));
        z_r    <= '0;
      end
      ST_SCAN: begin
        di_r  <= idx_r;
        ni_r  <= di_r;
        num_r <= num_full;
        if (nv_r) begin
          if (num_r > best_r) begin
            best_r <= num_r;
            imax_r <= ni_r;
            hot_r  <= 1'b1;
          end
          if ((ni_r == '0) || (num_r > nmax_r)) begin
            nmax_r <= num_r;
          end
        end
      end
      ST_WNUM: begin
        num_r <= num_full;
      end
      ST_WSUB: begin
        e_r <= CMP_W'(nmax_r - num_r);
      end
      ST_WCHK: begin
        wgt_r <= '0;
      end
      ST_WEXP: begin
        if (exp_vld) begin
          wgt_r <= exp_w;
        end
      end
      ST_WWR: begin
        z_r <= z_r + Z_W'(wgt_r);
      end
      ST_NDIV: begin
        if (div_done) begin
          pq_r <= (div_q > DIV_QW'(PROB_MAX)) ? 16'(PROB_MAX) : div_q[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (state_r == ST_RESP) begin
      out_prob_r <= '0;
      out_miss_r <= 1'b0;
      out_det_r  <= flag_r;
      out_cnt_r  <= cnt_r;
    end else if (state_r == ST_RDWAIT) begin
      out_prob_r <= hit_r ? pr_rdata[15:0] : 16'd0;
      out_miss_r <= !hit_r;
      out_det_r  <= flag_r;
      out_cnt_r  <= cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_probability   = out_prob_r;
  assign out_deterministic = out_det_r;
  assign out_entry_count   = 10'({{(32-CW){1'b0}}, out_cnt_r});
  assign out_index_miss    = out_miss_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-CW){1'b0}}, cnt_r} <= 32'(MAX_ENTRIES))
    else $error("entry count beyond store depth");

  a_no_weights_when_hot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRD) |-> !hot_r)
    else $error("weight pass entered after overflow");

  a_resp_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) |=> out_valid && !out_index_miss)
    else $error("closing load produced no result");
`endif

endmodule
